[rtl/bwkh_pkg.sv]
package bwkh_pkg;

    localparam logic [63:0] MIX_PRIME        = 64'hB2833106536E95DF;
    localparam logic [63:0] FALLBACK_PATTERN = 64'hAAAAAAAAAAAAAAAA;
    localparam logic [6:0]  MIN_REPAIR_WEIGHT = 7'd26;
    localparam logic [6:0]  TARGET_WEIGHT     = 7'd32;
    localparam logic [6:0]  FULL_WEIGHT       = 7'd64;
    localparam int          POS_W             = 6;

    // configuration register indexes
    localparam int          CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SALT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPAIR_ENABLE = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic load;      // x <= salted key
        logic mul;       // partial products, weight, complement
        logic sum;       // finish next
        logic step;      // one repair step
        logic advance;   // x <= next
        logic fallback;  // result is the alternating pattern
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic w_ge_min;
        logic w_eq_target;
    } t_status;

endpackage

[rtl/bwkh_dp.sv]
module bwkh_dp (
    input  logic             i_clk,
    input  bwkh_pkg::t_cmd   i_cmd,
    input  logic [63:0]      i_key,
    input  logic [63:0]      i_salt,
    output bwkh_pkg::t_status o_status,
    output logic [63:0]      o_x
);

    localparam logic [31:0] P_LO = bwkh_pkg::MIX_PRIME[31:0];
    localparam logic [31:0] P_HI = bwkh_pkg::MIX_PRIME[63:32];

    logic [63:0] r_x, n_x;
    logic [6:0]  r_w, n_w;
    logic [63:0] r_next, n_next;
    logic [63:0] r_sel, n_sel;
    logic [63:0] r_pp_ll;
    logic [31:0] r_pp_lh;
    logic [31:0] r_pp_hl;

    logic [63:0] w_mix;
    logic [63:0] w_ll;
    logic [31:0] w_lh;
    logic [31:0] w_hl;
    logic [6:0]  w_pop;
    logic [bwkh_pkg::POS_W-1:0] w_pos;

    assign w_mix = r_x ^ bwkh_pkg::MIX_PRIME;
    assign w_ll  = w_mix[31:0] * P_LO;
    assign w_lh  = w_mix[31:0] * P_HI;
    assign w_hl  = w_mix[63:32] * P_LO;
    assign w_pop = 7'($countones(r_x));
    assign w_pos = r_sel[bwkh_pkg::POS_W-1:0];

    always_comb begin
        n_x    = r_x;
        n_w    = r_w;
        n_next = r_next;
        n_sel  = r_sel;
        if (i_cmd.load) begin
            n_x = i_key ^ i_salt;
        end
        if (i_cmd.mul) begin
            if (w_pop > bwkh_pkg::TARGET_WEIGHT) begin
                n_x = ~r_x;
                n_w = bwkh_pkg::FULL_WEIGHT - w_pop;
            end else begin
                n_w = w_pop;
            end
        end
        if (i_cmd.sum) begin
            n_next = r_pp_ll + {r_pp_lh + r_pp_hl, 32'h0};
            n_sel  = n_next;
        end
        if (i_cmd.step) begin
            if (!r_x[w_pos]) begin
                n_x[w_pos] = 1'b1;
                n_w = r_w + 7'd1;
            end
            n_sel = r_sel >> bwkh_pkg::POS_W;
        end
        if (i_cmd.advance) begin
            n_x = r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_w    <= n_w;
        r_next <= n_next;
        r_sel  <= n_sel;
        if (i_cmd.mul) begin
            r_pp_ll <= w_ll;
            r_pp_lh <= w_lh;
            r_pp_hl <= w_hl;
        end
    end

    assign o_status.w_ge_min    = (r_w >= bwkh_pkg::MIN_REPAIR_WEIGHT);
    assign o_status.w_eq_target = (r_w == bwkh_pkg::TARGET_WEIGHT);
    assign o_x = r_x;

endmodule

[rtl/bwkh_ctrl.sv]
module bwkh_ctrl #(
    parameter int ROUND_LIMIT  = 16,
    parameter int REPAIR_TRIES = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_key_valid,
    output logic              o_key_ready,
    input  logic              i_out_free,
    input  logic              i_repair_en,
    input  bwkh_pkg::t_status i_status,
    output bwkh_pkg::t_cmd    o_cmd
);

    localparam int ROUND_W = $clog2(ROUND_LIMIT + 1);
    localparam int STEP_W  = $clog2(REPAIR_TRIES + 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_LIMIT - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(REPAIR_TRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_SUM    = 5'b00100,
        S_REPAIR = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_fallback, n_fallback;

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_step     = r_step;
        n_fallback = r_fallback;
        o_cmd      = '0;
        o_cmd.fallback = r_fallback;
        o_key_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_key_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_fallback = 1'b0;
                    n_state    = i_repair_en ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_step    = '0;
                n_state   = S_REPAIR;
            end
            S_REPAIR: begin
                if (i_status.w_ge_min && i_status.w_eq_target) begin
                    n_state = S_DONE;
                end else if (i_status.w_ge_min && r_step != LAST_STEP) begin
                    o_cmd.step = 1'b1;
                    n_step     = r_step + STEP_W'(1);
                end else if (r_round == LAST_ROUND) begin
                    n_fallback = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_round       = r_round + ROUND_W'(1);
                    n_state       = S_MUL;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= '0;
            r_step     <= '0;
            r_fallback <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_step     <= n_step;
            r_fallback <= n_fallback;
        end
    end

endmodule

[rtl/balanced_weight_key_hash.sv]
// With repair off the salted key is passed straight to the output register. With repair
// on, the block runs up to ROUND_LIMIT rounds, each with s repair steps taken (0..9).
// A round is a multiply (partial products, then final add), s one-bit repair steps and
// a state that returns x, falls back or advances; one item is in flight at a time.
// Throughput: a new key is taken the cycle after the result moves into the output register.
// Reset is synchronous, active low: salt clears to 0, repair is enabled, no item held.
module balanced_weight_key_hash #(
    parameter int ROUND_LIMIT  = 16,
    parameter int REPAIR_TRIES = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // key channel
    input  logic                           i_key_valid,
    output logic                           o_key_ready,
    input  logic [63:0]                    i_key,
    // hash channel
    output logic                           o_hash_valid,
    input  logic                           i_hash_ready,
    output logic [63:0]                    o_hashed_key,
    // configuration writes
    input  logic                           i_cfg_wr_en,
    input  logic [bwkh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_wr_data
);

    // configuration registers
    logic [63:0] r_salt;
    logic        r_repair_en;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;

    bwkh_pkg::t_cmd    w_cmd;
    bwkh_pkg::t_status w_status;
    logic [63:0]       w_x;
    logic [63:0]       w_result;
    logic              w_out_free;

    // Hold configuration; it must be written only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt      <= '0;
            r_repair_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                bwkh_pkg::CFG_QUERY_SALT:    r_salt      <= i_cfg_wr_data;
                bwkh_pkg::CFG_REPAIR_ENABLE: r_repair_en <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // The output register is free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || i_hash_ready;

    bwkh_ctrl #(
        .ROUND_LIMIT  (ROUND_LIMIT),
        .REPAIR_TRIES (REPAIR_TRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (i_key_valid),
        .o_key_ready (o_key_ready),
        .i_out_free  (w_out_free),
        .i_repair_en (r_repair_en),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bwkh_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_key    (i_key),
        .i_salt   (r_salt),
        .o_status (w_status),
        .o_x      (w_x)
    );

    // Pick the alternating pattern when every round ran out.
    assign w_result = w_cmd.fallback ? bwkh_pkg::FALLBACK_PATTERN : w_x;

    // Load the result when done; drop valid once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_hash_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_hash_valid = r_out_valid;
    assign o_hashed_key = r_out_data;

`ifndef SYNTHESIS
    // With repair on, a hash always carries exactly half its bits set.
    a_balanced_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && r_repair_en) |-> ($countones(w_result) == 32))
        else $error("repaired hash does not have 32 ones");

    // Never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_hash_ready))
        else $error("output register overwritten");

    // One item at a time: no key is taken right after another.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key_valid && o_key_ready) |=> !o_key_ready)
        else $error("second key accepted while busy");
`endif

endmodule

[bench/balanced_weight_key_hash_test.sv]
module balanced_weight_key_hash_test;

    localparam int ROUND_LIMIT   = 16;
    localparam int REPAIR_TRIES  = 10;
    localparam int MAX_GAP       = 14;
    // Worst item: the longest hashing run plus both sides' longest stalls, taken many times over.
    localparam int STALL_LIMIT   = 2000;
    // Longest latency of one item, waited out before the final verdict.
    localparam int TAIL_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 199;
    localparam int REPORT_LIMIT  = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        key_valid = 1'b0;
    logic        key_ready;
    logic [63:0] key_data = '0;
    logic        hash_valid;
    logic        hash_ready = 1'b0;
    logic [63:0] hashed_key;
    logic        cfg_wr_en = 1'b0;
    logic [bwkh_pkg::CFG_IDX_W-1:0] cfg_idx = bwkh_pkg::CFG_QUERY_SALT;
    logic [63:0] cfg_wr_data = '0;

    // Shadow copy of the configuration, matching the block's reset values.
    logic [63:0] salt_shadow = '0;
    logic        repair_shadow = 1'b1;

    logic [63:0] hash_q[$];     // expected hashes, oldest first
    int          bad_results = 0;
    int          stall_cycles = 0;
    bit          quiet = 1'b0;  // when set, neither side idles

    balanced_weight_key_hash u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_key_valid   (key_valid),
        .o_key_ready   (key_ready),
        .i_key         (key_data),
        .o_hash_valid  (hash_valid),
        .i_hash_ready  (hash_ready),
        .o_hashed_key  (hashed_key),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Balanced-weight hash of one salted key: rounds of multiply, complement and
    // bit repair until the value holds exactly TARGET_WEIGHT ones, else the fallback pattern.
    function automatic logic [63:0] balance_weight(input logic [63:0] seed);
        logic [63:0] x;
        logic [63:0] nxt;
        logic [5:0]  pos;
        int          ones;
        x = seed;
        for (int rnd = 0; rnd < ROUND_LIMIT; rnd++) begin
            nxt = bwkh_pkg::MIX_PRIME * (x ^ bwkh_pkg::MIX_PRIME);
            ones = $countones(x);
            // Fold heavy values into the lower half of the weight range.
            if (ones > bwkh_pkg::TARGET_WEIGHT) begin
                x = ~x;
                ones = 64 - ones;
            end
            if (ones >= bwkh_pkg::MIN_REPAIR_WEIGHT) begin
                for (int st = 0; st < REPAIR_TRIES; st++) begin
                    // The weight is checked before each step, never after the last.
                    if (ones == bwkh_pkg::TARGET_WEIGHT)
                        return x;
                    pos = 6'((nxt >> ((6 * st) & 63)) & 64'd63);
                    // A bit that is already set leaves x alone.
                    if (!x[pos]) begin
                        x[pos] = 1'b1;
                        ones++;
                    end
                end
            end
            x = nxt;
        end
        return bwkh_pkg::FALLBACK_PATTERN;
    endfunction

    function automatic logic [63:0] predict_hash(input logic [63:0] key);
        logic [63:0] salted;
        salted = key ^ salt_shadow;
        return repair_shadow ? balance_weight(salted) : salted;
    endfunction

    // Build a key whose salted value has the given number of ones.
    function automatic logic [63:0] weighted_key(input int ones);
        logic [63:0] v;
        v = '0;
        while ($countones(v) < ones)
            v[$urandom_range(0, 63)] = 1'b1;
        return v ^ salt_shadow;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Send one key; valid stays high from one item to the next when no gap is drawn.
    task automatic send_key(input logic [63:0] key);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= key;
        do @(posedge clk); while (!key_ready);
        hash_q.insert(hash_q.size(), predict_hash(key));
    endtask

    // Drop valid and hold until every expected hash has come back.
    task automatic wait_idle();
        key_valid <= 1'b0;
        while (hash_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Write both registers back to back; upper bits of the enable word are noise.
    task automatic set_config(input logic [63:0] salt, input logic enable);
        cfg_wr_en   <= 1'b1;
        cfg_idx     <= bwkh_pkg::CFG_QUERY_SALT;
        cfg_wr_data <= salt;
        @(posedge clk);
        cfg_idx     <= bwkh_pkg::CFG_REPAIR_ENABLE;
        cfg_wr_data <= {$urandom, 31'($urandom), enable};
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        salt_shadow   = salt;
        repair_shadow = enable;
    endtask

    // Hash consumer: stall for a random gap before each item (none when quiet), then check it.
    initial begin
        int stall;
        logic [63:0] want;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                hash_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hash_ready <= 1'b1;
            do @(posedge clk); while (!hash_valid);
            if (hash_q.size() == 0) begin
                if (bad_results < REPORT_LIMIT)
                    $display("unexpected hash %h with nothing pending", hashed_key);
                bad_results++;
            end else begin
                want = hash_q.pop_front();
                if (hashed_key !== want) begin
                    if (bad_results < REPORT_LIMIT)
                        $display("hashed_key mismatch: expected %h actual %h", want, hashed_key);
                    bad_results++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if ((key_valid && key_ready) || (hash_valid && hash_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Reset values: salt 0, repair on. Cover the weight boundaries of the first round.
    task automatic test_reset_defaults();
        send_key(64'h0);
        send_key('1);
        send_key(bwkh_pkg::FALLBACK_PATTERN);
        send_key(~bwkh_pkg::FALLBACK_PATTERN);
        send_key(64'h0000_0000_FFFF_FFFF);   // exactly 32 ones: returned at once
        send_key(64'h0000_0000_7FFF_FFFF);   // 31 ones: one repair step needed
        send_key(64'h0000_0001_FFFF_FFFF);   // 33 ones: complemented first
        send_key(64'h0000_0000_03FF_FFFF);   // 26 ones: lowest weight that repairs
        send_key(64'h0000_0000_01FF_FFFF);   // 25 ones: skip repair, advance
        send_key(64'h0000_003F_FFFF_FFFF);   // 38 ones: folds to 26
        send_key(64'h0000_007F_FFFF_FFFF);   // 39 ones: folds to 25
        send_key(64'h1);
        send_key(64'h8000_0000_0000_0000);
        wait_idle();
    endtask

    // With repair off the salted key passes straight through.
    task automatic test_repair_off();
        set_config(64'h0, 1'b0);
        send_key(64'h0);
        send_key('1);
        wait_idle();
        set_config('1, 1'b0);
        send_key(64'h0);
        send_key(64'h0123_4567_89AB_CDEF);
        wait_idle();
    endtask

    // Extreme and mixed salts with repair back on.
    task automatic test_salt_extremes();
        set_config('1, 1'b1);
        send_key(64'h0);
        send_key('1);
        send_key(64'hFFFF_FFFF_0000_0000);
        wait_idle();
        set_config(64'h8000_0000_0000_0001, 1'b1);
        send_key(64'h8000_0000_0000_0001);
        wait_idle();
    endtask

    // Random phases over several settings. Most keys are steered to salted weights
    // around the repair window so that repair steps and extra rounds run often.
    task automatic test_random_phases();
        logic [63:0] salt;
        logic        enable;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin salt = '0; enable = 1'b1; end
                1: begin salt = '1; enable = 1'b1; end
                2: begin salt = '0; enable = 1'b0; end
                5: begin salt = {$urandom, $urandom}; enable = 1'b0; end
                default: begin salt = {$urandom, $urandom}; enable = 1'b1; end
            endcase
            set_config(salt, enable);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Toggle stretches without idling on both sides.
                if (n % 40 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 7)
                    send_key(weighted_key($urandom_range(20, 44)));
                else
                    send_key({$urandom, $urandom});
            end
            quiet = 1'b0;
            wait_idle();
        end
    endtask

    // Hold the sender until the block has drained, then resume.
    task automatic test_drain_pause();
        set_config({$urandom, $urandom}, 1'b1);
        for (int n = 0; n < 40; n++) begin
            if (n == 20) begin
                key_valid <= 1'b0;
                while (hash_q.size() != 0) @(posedge clk);
            end
            send_key(weighted_key($urandom_range(24, 40)));
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_repair_off();
        test_salt_extremes();
        test_random_phases();
        test_drain_pause();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_results == 0 && hash_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
